/* rtl/assert_macros.svh */
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ddc_tp_pkg.sv */
// types, constants and band lookup for the tuning planner
// no dependencies
package ddc_tp_pkg;

	localparam logic [27:0] FREQ_MAX          = 28'd150000000;
	localparam logic [27:0] SAMPLE_RATE_RESET = 28'd122880000;
	localparam logic [30:0] PHASE_MUL         = 31'd1172812403;
	localparam logic [24:0] PHASE_ROUND       = 25'd16777216;
	localparam int          PHASE_SHIFT       = 25;
	localparam int          PROD_W            = 28 + 31;

	localparam logic [1:0] ZONE_1 = 2'd1;
	localparam logic [1:0] ZONE_2 = 2'd2;
	localparam logic [1:0] ZONE_3 = 2'd3;

	localparam logic [1:0] FLT_LPF = 2'd0;
	localparam logic [1:0] FLT_4M  = 2'd1;
	localparam logic [1:0] FLT_2M  = 2'd3;

	localparam logic [15:0] CTRL_RESET    = 16'h8069;
	localparam logic [15:0] CTRL_FLT_MASK = 16'h0180;
	localparam logic [15:0] CTRL_IQ_SWAP  = 16'h0004;
	localparam logic [15:0] CTRL_DAC_ATT  = 16'h0800;
	localparam int          CTRL_FLT_LSB  = 7;

	localparam logic [7:0] AMP_HF_BIT  = 8'h04;
	localparam logic [7:0] BOARD_RESET = 8'hFF;

	localparam logic CFG_SAMPLE_RATE = 1'b0;
	localparam logic CFG_IF_OFFSET   = 1'b1;

	localparam int NUM_BANDS = 7;

	localparam logic signed [29:0] BAND_LO [NUM_BANDS] = '{
		30'sd1810000, 30'sd3500000, 30'sd5100000, 30'sd10100000,
		30'sd18000000, 30'sd24890000, 30'sd50000000
	};
	localparam logic signed [29:0] BAND_HI [NUM_BANDS] = '{
		30'sd2000000, 30'sd3800000, 30'sd7200000, 30'sd14350000,
		30'sd21450000, 30'sd29700000, 30'sd52000000
	};
	localparam logic [2:0] BAND_CODE [NUM_BANDS] = '{
		3'd2, 3'd6, 3'd3, 3'd5, 3'd7, 3'd4, 3'd1
	};

	typedef struct packed {
		logic [27:0] freq;
		logic [1:0]  zone;
		logic [15:0] ctrl;
		logic        ctrl_chg;
		logic [7:0]  bbyte;
		logic        board_chg;
	} plan_t;

	function automatic logic [2:0] band_code(input logic signed [29:0] dial);
		logic [2:0] code;
		code = 3'd0;
		for (int i = NUM_BANDS - 1; i >= 0; i--) begin
			if (dial >= BAND_LO[i] && dial < BAND_HI[i]) begin
				code = BAND_CODE[i];
			end
		end
		return code;
	endfunction

endpackage

/* rtl/ddc_tp_fold.sv */
// zone folding, band choice and control/board change tracking
// depends on ddc_tp_pkg
module ddc_tp_fold (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                take,
	input  logic [27:0]         freq,
	input  logic [27:0]         sample_rate,
	input  logic signed [17:0]  if_offset,
	output ddc_tp_pkg::plan_t   plan_s2
);

	logic [27:0]        f_cl;
	logic [27:0]        half;
	logic [27:0]        fold;
	logic [1:0]         zone;
	logic [1:0]         filter;
	logic [2:0]         band;
	logic signed [29:0] dial;
	logic [7:0]         bbyte;
	logic [15:0]        ctrl_nxt;
	logic               ctrl_chg;
	logic               board_chg;
	logic [15:0]        ctrl_q;
	logic [1:0]         last_filter_q;
	logic [7:0]         last_bbyte_q;

	assign f_cl = (freq > ddc_tp_pkg::FREQ_MAX) ? ddc_tp_pkg::FREQ_MAX : freq;
	assign half = sample_rate >> 1;
	// dial only matters in zone 1, where the folded frequency is the clamped one
	assign dial = $signed({2'b00, f_cl}) - $signed({{12{if_offset[17]}}, if_offset});

	always_comb begin
		band = 3'd0;
		if (f_cl >= sample_rate) begin
			fold   = f_cl - sample_rate;
			zone   = ddc_tp_pkg::ZONE_3;
			filter = ddc_tp_pkg::FLT_2M;
		end else if (f_cl >= half) begin
			fold   = half - (f_cl - half);
			zone   = ddc_tp_pkg::ZONE_2;
			filter = ddc_tp_pkg::FLT_4M;
		end else begin
			fold   = f_cl;
			zone   = ddc_tp_pkg::ZONE_1;
			filter = ddc_tp_pkg::FLT_LPF;
			band   = ddc_tp_pkg::band_code(dial);
		end
	end

	assign bbyte = {1'b0, band, 4'b0000} | ddc_tp_pkg::AMP_HF_BIT;

	always_comb begin
		ctrl_nxt = ctrl_q;
		ctrl_chg = (filter != last_filter_q);
		if (ctrl_chg) begin
			ctrl_nxt = ctrl_q & ~ddc_tp_pkg::CTRL_FLT_MASK;
			if (zone == ddc_tp_pkg::ZONE_2) begin
				ctrl_nxt = ctrl_nxt | ddc_tp_pkg::CTRL_IQ_SWAP;
			end else begin
				ctrl_nxt = ctrl_nxt & ~ddc_tp_pkg::CTRL_IQ_SWAP;
			end
			if (zone == ddc_tp_pkg::ZONE_3) begin
				ctrl_nxt = ctrl_nxt & ~ddc_tp_pkg::CTRL_DAC_ATT;
			end else begin
				ctrl_nxt = ctrl_nxt | ddc_tp_pkg::CTRL_DAC_ATT;
			end
			ctrl_nxt = ctrl_nxt | ({14'd0, filter} << ddc_tp_pkg::CTRL_FLT_LSB);
		end
	end

	assign board_chg = (bbyte != last_bbyte_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q        <= ddc_tp_pkg::CTRL_RESET;
			last_filter_q <= ddc_tp_pkg::FLT_LPF;
			last_bbyte_q  <= ddc_tp_pkg::BOARD_RESET;
		end else if (take) begin
			ctrl_q        <= ctrl_nxt;
			last_filter_q <= filter;
			last_bbyte_q  <= bbyte;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plan_s2.freq      <= fold;
			plan_s2.zone      <= zone;
			plan_s2.ctrl      <= ctrl_nxt;
			plan_s2.ctrl_chg  <= ctrl_chg;
			plan_s2.bbyte     <= bbyte;
			plan_s2.board_chg <= board_chg;
		end
	end

endmodule

/* rtl/ddc_tp_phase.sv */
// phase increment multiply with rounding, result register
// depends on ddc_tp_pkg
module ddc_tp_phase (
	input  logic              clk,
	input  logic              en,
	input  ddc_tp_pkg::plan_t plan_s2,
	output logic [31:0]       phase_step,
	output logic [1:0]        zone,
	output logic [15:0]       ctrl_word,
	output logic              ctrl_changed,
	output logic [7:0]        board_byte,
	output logic              board_changed
);

	localparam int PW = ddc_tp_pkg::PROD_W;

	logic [PW-1:0] prod;
	logic [PW-1:0] rounded;

	assign prod    = PW'(plan_s2.freq) * PW'(ddc_tp_pkg::PHASE_MUL);
	assign rounded = prod + PW'(ddc_tp_pkg::PHASE_ROUND);

	always_ff @(posedge clk) begin
		if (en) begin
			phase_step    <= rounded[ddc_tp_pkg::PHASE_SHIFT+31:ddc_tp_pkg::PHASE_SHIFT];
			zone          <= plan_s2.zone;
			ctrl_word     <= plan_s2.ctrl;
			ctrl_changed  <= plan_s2.ctrl_chg;
			board_byte    <= plan_s2.bbyte;
			board_changed <= plan_s2.board_chg;
		end
	end

endmodule

/* rtl/ddc_tuning_planner.sv */
// top level of the tuning planner: config registers, pipeline control
// depends on ddc_tp_pkg, ddc_tp_fold, ddc_tp_phase
//
// Three-stage pipeline taking one tuning request per clock unless stalled
// and giving one result per request, in order. Stage one registers the
// request, stage two folds it into the first Nyquist zone, picks the band
// and updates the control and board tracking state, stage three forms the
// phase increment with one 28x31 multiply. Sustained rate is one
// transaction per cycle while out_stall is low; in_stall follows out_stall
// through the pipeline when all stages are full. The user must write
// sample_rate and if_offset on the cfg port only while idle (unenforced).
module ddc_tuning_planner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [27:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [27:0]        tune_freq,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        phase_step,
	output logic [1:0]         zone,
	output logic [15:0]        ctrl_word,
	output logic               ctrl_changed,
	output logic [7:0]         board_byte,
	output logic               board_changed
);

	logic [27:0]        sample_rate_q;
	logic signed [17:0] if_offset_q;
	logic [27:0]        tune_freq_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               adv1;
	logic               adv2;
	logic               adv3;
	ddc_tp_pkg::plan_t  plan_s2;

	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= ddc_tp_pkg::SAMPLE_RATE_RESET;
			if_offset_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ddc_tp_pkg::CFG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				ddc_tp_pkg::CFG_IF_OFFSET:   if_offset_q   <= $signed(cfg_data[17:0]);
				default:                     sample_rate_q <= sample_rate_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			tune_freq_s1 <= tune_freq;
		end
	end

	ddc_tp_fold u_fold (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv2),
		.take        (valid_s1 && adv2),
		.freq        (tune_freq_s1),
		.sample_rate (sample_rate_q),
		.if_offset   (if_offset_q),
		.plan_s2     (plan_s2)
	);

	ddc_tp_phase u_phase (
		.clk           (clk),
		.en            (adv3),
		.plan_s2       (plan_s2),
		.phase_step    (phase_step),
		.zone          (zone),
		.ctrl_word     (ctrl_word),
		.ctrl_changed  (ctrl_changed),
		.board_byte    (board_byte),
		.board_changed (board_changed)
	);

endmodule

/* rtl/ddc_tp_checker.sv */
// port-level checks for the tuning planner, bound to the top level
// depends on ddc_tp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ddc_tp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] phase_step,
	input logic [1:0]  zone,
	input logic [15:0] ctrl_word,
	input logic [7:0]  board_byte
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(phase_step) && $stable(ctrl_word), "result changed while stalled")
	`ASSERT_IMPL(a_zone3_filter, clk, arst_n, out_valid && zone == ddc_tp_pkg::ZONE_3, ctrl_word[8:7] == ddc_tp_pkg::FLT_2M && !ctrl_word[11], "zone 3 control word mismatch")
	`ASSERT_IMPL(a_zone2_filter, clk, arst_n, out_valid && zone == ddc_tp_pkg::ZONE_2, ctrl_word[8:7] == ddc_tp_pkg::FLT_4M && ctrl_word[2], "zone 2 control word mismatch")
	`ASSERT_IMPL(a_zone1_board, clk, arst_n, out_valid && zone == ddc_tp_pkg::ZONE_1, ctrl_word[8:7] == ddc_tp_pkg::FLT_LPF && (board_byte & 8'h8F) == ddc_tp_pkg::AMP_HF_BIT, "zone 1 output mismatch")
	`ASSERT_IMPL(a_upper_board, clk, arst_n, out_valid && zone != ddc_tp_pkg::ZONE_1, board_byte == ddc_tp_pkg::AMP_HF_BIT, "board byte in upper zone")

endmodule

bind ddc_tuning_planner ddc_tp_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.phase_step (phase_step),
	.zone       (zone),
	.ctrl_word  (ctrl_word),
	.board_byte (board_byte)
);
